[src/bounded_stack_with_search_top_macros.svh]
// assertion macros for the bounded stack checker
// every macro samples on the rising edge of clock and is off during reset
`ifndef BOUNDED_STACK_WITH_SEARCH_TOP_MACROS_SVH
`define BOUNDED_STACK_WITH_SEARCH_TOP_MACROS_SVH

// same-cycle implication
`define BSS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bss check failed: same-cycle rule");

// next-cycle implication
`define BSS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bss check failed: next-cycle rule");

`endif

[src/bss_pkg.sv]
// ----------------------------------------------------------------------------
// bss_pkg
// shared sizes, field types and codes of the bounded stack with search
// ----------------------------------------------------------------------------
`default_nettype none

package bss_pkg;

   // storage geometry
   localparam int DEPTH        = 16;
   localparam int RESULT_LIMIT = 16;
   localparam int IDX_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W        = $clog2(DEPTH + 1);
   localparam int RES_W        = $clog2(RESULT_LIMIT + 1);

   // beat field widths
   localparam int ACT_W    = 2;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 3;
   localparam int POS_W    = 5;

   typedef logic [ACT_W-1:0]           action_type;
   typedef logic signed [DATA_W-1:0]   word_type;
   typedef logic [STATUS_W-1:0]        status_type;
   typedef logic [POS_W-1:0]           pos_type;

   // action codes
   localparam action_type ACT_PUSH   = 2'd0;
   localparam action_type ACT_POP    = 2'd1;
   localparam action_type ACT_SEARCH = 2'd2;
   localparam action_type ACT_DUMP   = 2'd3;

   // result status codes
   localparam status_type ST_PUSHED    = 3'd0;
   localparam status_type ST_OVERFLOW  = 3'd1;
   localparam status_type ST_POPPED    = 3'd2;
   localparam status_type ST_UNDERFLOW = 3'd3;
   localparam status_type ST_FOUND     = 3'd4;
   localparam status_type ST_NOT_FOUND = 3'd5;
   localparam status_type ST_EMPTY     = 3'd6;
   localparam status_type ST_DUMP_ITEM = 3'd7;

endpackage

`default_nettype wire

[src/bss_if.sv]
// ----------------------------------------------------------------------------
// bss_req_if / bss_rsp_if
// valid/ready channels for request beats and result beats
// ----------------------------------------------------------------------------
`default_nettype none

interface bss_req_if;
   logic                 valid;
   logic                 ready;
   bss_pkg::action_type  action;
   bss_pkg::word_type    value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

interface bss_rsp_if;
   logic                 valid;
   logic                 ready;
   bss_pkg::status_type  status;
   bss_pkg::word_type    data;
   bss_pkg::pos_type     position;
   bss_pkg::pos_type     occupancy;
   logic                 last;

   modport source (output valid, output status, output data, output position,
                   output occupancy, output last, input ready);
   modport sink   (input valid, input status, input data, input position,
                   input occupancy, input last, output ready);
endinterface

`default_nettype wire

[src/bounded_stack_with_search_top.sv]
// push/overflow: S_EXEC writes the result register and returns to idle (ready) together
// pop: S_EXEC issues the registered stack read, S_POPRD returns the popped word
// search/dump: S_EXEC, S_WALK, S_FLUSH; one entry a cycle through the single read port while the result port is free
// underflow/empty: answered from S_EXEC; a stalled result port holds the sequencer
// synchronous reset empties the stack; entries stay undefined, no clearing pass
// ----------------------------------------------------------------------------
// bounded_stack_with_search_top
// fixed-depth lifo of signed words with push, pop, search and dump
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_stack_with_search_top (
   input  wire logic  clock,
   input  wire logic  reset,
   bss_req_if.sink    req_bus,
   bss_rsp_if.source  rsp_bus
);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_POPRD = 3'd2;
   localparam logic [2:0] S_WALK  = 3'd3;
   localparam logic [2:0] S_FLUSH = 3'd4;

   logic [2:0]                    state_ff, state_in;
   bss_pkg::action_type           act_ff, act_in;
   bss_pkg::word_type             key_ff, key_in;
   logic [bss_pkg::CNT_W-1:0]     fill_ff, fill_in;
   logic [bss_pkg::IDX_W-1:0]     idx_ff, idx_in;
   logic [bss_pkg::RES_W-1:0]     hits_ff, hits_in;
   logic                          hold_valid_ff, hold_valid_in;
   bss_pkg::word_type             hold_data_ff, hold_data_in;
   bss_pkg::pos_type              hold_pos_ff, hold_pos_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   bss_pkg::status_type           rsp_status_ff, rsp_status_in;
   bss_pkg::word_type             rsp_data_ff, rsp_data_in;
   bss_pkg::pos_type              rsp_pos_ff, rsp_pos_in;
   bss_pkg::pos_type              rsp_occ_ff, rsp_occ_in;
   logic                          rsp_last_ff, rsp_last_in;

   // stack storage and its single read port
   bss_pkg::word_type             mem_ff [bss_pkg::DEPTH];
   bss_pkg::word_type             rd_data_ff;
   logic                          wr_en;
   logic                          rd_en;
   logic [bss_pkg::IDX_W-1:0]     rd_addr;

   logic                          accept;
   logic                          out_free;
   logic                          emit;
   logic                          entry_match;
   logic                          entry_last;
   logic                          limit_hit;
   logic [bss_pkg::CNT_W-1:0]     idx_plus;
   logic [bss_pkg::CNT_W-1:0]     fill_dec;

   assign accept   = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready    = (state_ff == S_IDLE);
   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.status   = rsp_status_ff;
   assign rsp_bus.data     = rsp_data_ff;
   assign rsp_bus.position = rsp_pos_ff;
   assign rsp_bus.occupancy = rsp_occ_ff;
   assign rsp_bus.last     = rsp_last_ff;

   // walk helpers
   assign idx_plus    = bss_pkg::CNT_W'(idx_ff) + bss_pkg::CNT_W'(1);
   assign fill_dec    = fill_ff - bss_pkg::CNT_W'(1);
   assign entry_match = (act_ff == bss_pkg::ACT_DUMP) || (rd_data_ff == key_ff);
   assign entry_last  = (idx_plus == fill_ff);
   assign limit_hit   = (hits_ff + bss_pkg::RES_W'(1)) == bss_pkg::RES_W'(bss_pkg::RESULT_LIMIT);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      key_in        = key_ff;
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      hits_in       = hits_ff;
      hold_valid_in = hold_valid_ff;
      hold_data_in  = hold_data_ff;
      hold_pos_in   = hold_pos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;
      emit          = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               act_in   = req_bus.action;
               key_in   = req_bus.value;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            if (out_free) begin
               state_in = S_IDLE;
               case (act_ff)
                  bss_pkg::ACT_PUSH: begin
                     emit        = 1'b1;
                     rsp_last_in = 1'b1;
                     rsp_pos_in  = '0;
                     if (fill_ff == bss_pkg::CNT_W'(bss_pkg::DEPTH)) begin
                        rsp_status_in = bss_pkg::ST_OVERFLOW;
                        rsp_data_in   = '0;
                     end else begin
                        wr_en         = 1'b1;
                        fill_in       = fill_ff + bss_pkg::CNT_W'(1);
                        rsp_status_in = bss_pkg::ST_PUSHED;
                        rsp_data_in   = key_ff;
                     end
                  end
                  bss_pkg::ACT_POP: begin
                     if (fill_ff == '0) begin
                        emit          = 1'b1;
                        rsp_last_in   = 1'b1;
                        rsp_pos_in    = '0;
                        rsp_status_in = bss_pkg::ST_UNDERFLOW;
                        rsp_data_in   = '0;
                     end else begin
                        fill_in  = fill_dec;
                        rd_en    = 1'b1;
                        rd_addr  = fill_dec[bss_pkg::IDX_W-1:0];
                        state_in = S_POPRD;
                     end
                  end
                  default: begin
                     if (fill_ff == '0) begin
                        emit          = 1'b1;
                        rsp_last_in   = 1'b1;
                        rsp_pos_in    = '0;
                        rsp_status_in = bss_pkg::ST_EMPTY;
                        rsp_data_in   = '0;
                     end else begin
                        idx_in        = '0;
                        hits_in       = '0;
                        hold_valid_in = 1'b0;
                        rd_en         = 1'b1;
                        rd_addr       = '0;
                        state_in      = S_WALK;
                     end
                  end
               endcase
            end
         end

         S_POPRD: begin
            if (out_free) begin
               emit          = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_pos_in    = '0;
               rsp_status_in = bss_pkg::ST_POPPED;
               rsp_data_in   = rd_data_ff;
               state_in      = S_IDLE;
            end
         end

         // one entry a cycle while the result port is free; a match waits in the
         // hold slot until the next one shows up or the walk ends, so its last flag is known
         S_WALK: begin
            if (out_free) begin
               if (entry_match) begin
                  if (hold_valid_ff) begin
                     emit          = 1'b1;
                     rsp_last_in   = 1'b0;
                     rsp_pos_in    = hold_pos_ff;
                     rsp_data_in   = hold_data_ff;
                     rsp_status_in = (act_ff == bss_pkg::ACT_DUMP) ?
                                     bss_pkg::ST_DUMP_ITEM : bss_pkg::ST_FOUND;
                  end
                  hold_valid_in = 1'b1;
                  hold_data_in  = rd_data_ff;
                  hold_pos_in   = bss_pkg::POS_W'(idx_plus);
                  hits_in       = hits_ff + bss_pkg::RES_W'(1);
               end
               if (entry_last || (entry_match && limit_hit)) begin
                  state_in = S_FLUSH;
               end else begin
                  idx_in  = idx_ff + bss_pkg::IDX_W'(1);
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + bss_pkg::IDX_W'(1);
               end
            end
         end

         S_FLUSH: begin
            if (out_free) begin
               emit          = 1'b1;
               rsp_last_in   = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = S_IDLE;
               if (hold_valid_ff) begin
                  rsp_pos_in    = hold_pos_ff;
                  rsp_data_in   = hold_data_ff;
                  rsp_status_in = (act_ff == bss_pkg::ACT_DUMP) ?
                                  bss_pkg::ST_DUMP_ITEM : bss_pkg::ST_FOUND;
               end else begin
                  rsp_pos_in    = '0;
                  rsp_data_in   = key_ff;
                  rsp_status_in = bss_pkg::ST_NOT_FOUND;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // every result beat reports the fill after the operation
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_occ_in   = bss_pkg::POS_W'(fill_in);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_ff       <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      hits_ff       <= hits_in;
      hold_data_ff  <= hold_data_in;
      hold_pos_ff   <= hold_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // stack memory, write at the fill pointer, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[fill_ff[bss_pkg::IDX_W-1:0]] <= key_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[src/bss_checker.sv]
// ----------------------------------------------------------------------------
// bss_checker
// port-level checks of the bounded stack, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "bounded_stack_with_search_top_macros.svh"

module bss_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire bss_pkg::status_type  rsp_status,
   input wire bss_pkg::word_type    rsp_data,
   input wire bss_pkg::pos_type     rsp_position,
   input wire bss_pkg::pos_type     rsp_occupancy,
   input wire logic                 rsp_last
);

   // a stalled result beat holds its status, data, position and last flag
   `BSS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_data) && $stable(rsp_position) && $stable(rsp_last))

   // the block works on one request at a time
   `BSS_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

   // only match and dump beats carry a position
   `BSS_ASSERT_NOW(a_pos_zero, rsp_valid && rsp_status != bss_pkg::ST_FOUND && rsp_status != bss_pkg::ST_DUMP_ITEM, rsp_position == '0)

   // overflow is reported only on a full stack, as a single beat
   `BSS_ASSERT_NOW(a_overflow_full, rsp_valid && rsp_status == bss_pkg::ST_OVERFLOW, rsp_last && rsp_occupancy == bss_pkg::POS_W'(bss_pkg::DEPTH))

endmodule

bind bounded_stack_with_search_top bss_checker u_bss_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_status    (rsp_bus.status),
   .rsp_data      (rsp_bus.data),
   .rsp_position  (rsp_bus.position),
   .rsp_occupancy (rsp_bus.occupancy),
   .rsp_last      (rsp_bus.last)
);

`default_nettype wire
